// ===== src/pmau_pkg.sv =====
// ----------------------------------------------------------------------------
// pmau_pkg
// Shared widths, codes and defaults of the paged memory access unit.
// ----------------------------------------------------------------------------
package pmau_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned FAULT_W = 2;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DIR_LSB  = 22;
  localparam int unsigned TAB_LSB  = 12;
  localparam int unsigned PAGE_LSB = 12;

  localparam int unsigned FUNC_WRITE_BIT = 0;
  localparam int unsigned FUNC_VIRT_BIT  = 1;
  localparam int unsigned ENTRY_PRESENT_BIT = 0;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGING_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_FRAME = 2'd1;

  typedef enum logic [FAULT_W-1:0] {
    FLT_NONE  = 2'd0,
    FLT_DIR   = 2'd1,
    FLT_TAB   = 2'd2,
    FLT_RANGE = 2'd3
  } fault_t;

endpackage

// ===== src/pmau_if.sv =====
// ----------------------------------------------------------------------------
// pmau_if
// Valid/ready channels of the paged memory access unit: access requests,
// access results and register writes.
// ----------------------------------------------------------------------------
interface pmau_in_if;
  import pmau_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  access_len;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, func, address, access_len, write_data, input ready);
  modport sink   (input valid, func, address, access_len, write_data, output ready);
endinterface

interface pmau_out_if;
  import pmau_pkg::*;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [ADDR_W-1:0]  phys_address;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, read_data, phys_address, fault, input ready);
  modport sink   (input valid, read_data, phys_address, fault, output ready);
endinterface

interface pmau_cfg_if;
  import pmau_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/paged_memory_access_unit_top.sv =====
// ----------------------------------------------------------------------------
// paged_memory_access_unit_top
// Byte memory with 1..4 byte little-endian accesses and a two-level page walk.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   one access word: func, address, access_len, write_data.
//   out_ch  one result word per access: read_data, phys_address, fault.
//   cfg_ch  register writes (paging enable, directory frame); always ready,
//           write only while no access is in flight.
// The memory is four byte banks with one port each; a page entry is read
// from all banks in one cycle, a data byte from one bank per cycle.
// Steps of an access: a translated access first walks the page tables (directory
// read, directory entry check, table entry check) and repeats the walk for each
// byte when it spans a page; every access then has a range check, the data
// steps byte by byte and a final step that loads the result.
// in_ch is ready only when the unit is idle; one access is worked at a time.
// The next access can be taken in the cycle after the result is loaded.
// A finished result waits in the output register while the next access is
// taken; a stalled receiver holds the unit at its final step.
// Reset clears the sequencer, the output valid and both registers; memory
// contents are kept and are undefined until written.
// ----------------------------------------------------------------------------
module paged_memory_access_unit_top #(
  parameter int unsigned MEM_BYTES = pmau_pkg::MEM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pmau_in_if.sink    in_ch,
  pmau_out_if.source out_ch,
  pmau_cfg_if.sink   cfg_ch
);
  import pmau_pkg::*;

  localparam int unsigned BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int unsigned WAW        = $clog2(BANK_DEPTH);
  localparam logic [ADDR_W:0] MEM_LIM = (ADDR_W+1)'(MEM_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIR   = 7'b0000010,
    S_DIRW  = 7'b0000100,
    S_TABW  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_DATA  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                paging_en_r;
  logic [FRAME_W-1:0]  dir_frame_r;
  logic                wr_op_r;
  logic                split_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   wdata_r;
  logic [1:0]          last_r;
  logic [1:0]          idx_r;
  logic [ADDR_W-1:0]   pa_r [4];
  fault_t              fault_r;
  logic [DATA_W-1:0]   rdata_r;
  logic                cap_vld_r;
  logic [1:0]          cap_lane_r;
  logic [1:0]          cap_pos_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_rdata_r;
  logic [ADDR_W-1:0]   out_pa_r;
  fault_t              out_fault_r;

  logic                in_acc, out_acc;
  logic [1:0]          in_last;
  logic [ADDR_W-1:0]   in_last_va;
  logic                in_translate;
  logic [ADDR_W-1:0]   va;
  logic [ADDR_W-1:0]   dir_addr, tab_addr, walk_pa, cur_pa;
  logic [DATA_W-1:0]   entry;
  logic                dir_ok, tab_ok;
  logic                range_bad;
  logic [WAW-1:0]      mem_idx;
  logic [3:0]          bank_we;
  logic [7:0]          wbyte;
  logic [3:0][7:0]     bank_q_r;
  logic [DATA_W-1:0]   rdata_merged;
  logic                done_load;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.phys_address = out_pa_r;
  assign out_ch.fault        = out_fault_r;

  always_comb begin
    if (in_ch.access_len == '0) begin
      in_last = 2'd0;
    end else if (in_ch.access_len > 3'd4) begin
      in_last = 2'd3;
    end else begin
      in_last = 2'(in_ch.access_len - 3'd1);
    end
  end

  assign in_last_va   = in_ch.address + ADDR_W'(in_last);
  assign in_translate = in_ch.func[FUNC_VIRT_BIT] && paging_en_r;

  assign va       = addr_r + ADDR_W'(idx_r);
  assign dir_addr = {dir_frame_r, va[ADDR_W-1:DIR_LSB], 2'b00};
  assign entry    = bank_q_r;
  assign tab_addr = {entry[ADDR_W-1:PAGE_LSB], va[DIR_LSB-1:TAB_LSB], 2'b00};
  assign walk_pa  = {entry[ADDR_W-1:PAGE_LSB], va[PAGE_LSB-1:0]};
  assign dir_ok   = ({1'b0, dir_addr} + (ADDR_W+1)'(4)) <= MEM_LIM;
  assign tab_ok   = ({1'b0, tab_addr} + (ADDR_W+1)'(4)) <= MEM_LIM;
  assign cur_pa   = pa_r[idx_r];

  always_comb begin
    range_bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) <= last_r && ({1'b0, pa_r[i]} >= MEM_LIM)) begin
        range_bad = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_DIRW:  mem_idx = tab_addr[WAW+1:2];
      S_DATA:  mem_idx = cur_pa[WAW+1:2];
      default: mem_idx = dir_addr[WAW+1:2];
    endcase
  end

  assign wbyte = 8'(wdata_r >> {idx_r, 3'b000});

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = (state_r == S_DATA) && wr_op_r && (cur_pa[1:0] == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[mem_idx] <= wbyte;
      end
      bank_q_r[b] <= mem[mem_idx];
    end
  end

  assign rdata_merged = rdata_r |
    (cap_vld_r ? (DATA_W'(bank_q_r[cap_lane_r]) << {cap_pos_r, 3'b000}) : '0);

  assign done_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = in_translate ? S_DIR : S_CHECK;
      S_DIR:   state_nxt = dir_ok ? S_DIRW : S_DONE;
      S_DIRW: begin
        if (!entry[ENTRY_PRESENT_BIT] || !tab_ok) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TABW;
        end
      end
      S_TABW: begin
        if (!entry[ENTRY_PRESENT_BIT]) begin
          state_nxt = S_DONE;
        end else if (split_r && idx_r != last_r) begin
          state_nxt = S_DIR;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = range_bad ? S_DONE : S_DATA;
      S_DATA:  if (idx_r == last_r) state_nxt = S_DONE;
      S_DONE:  if (done_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      paging_en_r <= 1'b0;
      dir_frame_r <= '0;
      out_valid_r <= 1'b0;
      cap_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cap_vld_r <= (state_r == S_DATA) && !wr_op_r;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_PAGING_EN) begin
          paging_en_r <= cfg_ch.data[0];
        end else if (cfg_ch.index == CFG_DIR_FRAME) begin
          dir_frame_r <= cfg_ch.data[FRAME_W-1:0];
        end
      end
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_lane_r <= cur_pa[1:0];
    cap_pos_r  <= idx_r;
    if (cap_vld_r) begin
      rdata_r <= rdata_merged;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wr_op_r    <= in_ch.func[FUNC_WRITE_BIT];
          addr_r     <= in_ch.address;
          wdata_r    <= in_ch.write_data;
          last_r     <= in_last;
          split_r    <= (in_last_va[ADDR_W-1:PAGE_LSB] != in_ch.address[ADDR_W-1:PAGE_LSB]);
          idx_r      <= 2'd0;
          fault_r    <= FLT_NONE;
          rdata_r    <= '0;
          for (int i = 0; i < 4; i++) begin
            pa_r[i] <= in_ch.address + ADDR_W'(i);
          end
        end
      end
      S_DIR: begin
        if (!dir_ok) fault_r <= FLT_RANGE;
      end
      S_DIRW: begin
        if (!entry[ENTRY_PRESENT_BIT]) begin
          fault_r <= FLT_DIR;
        end else if (!tab_ok) begin
          fault_r <= FLT_RANGE;
        end
      end
      S_TABW: begin
        if (!entry[ENTRY_PRESENT_BIT]) begin
          fault_r <= FLT_TAB;
        end else if (split_r) begin
          pa_r[idx_r] <= walk_pa;
          if (idx_r != last_r) begin
            idx_r <= idx_r + 2'd1;
          end else begin
            idx_r <= 2'd0;
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            pa_r[i] <= walk_pa + ADDR_W'(i);
          end
          idx_r <= 2'd0;
        end
      end
      S_CHECK: begin
        idx_r <= 2'd0;
        if (range_bad) fault_r <= FLT_RANGE;
      end
      S_DATA: begin
        if (idx_r != last_r) idx_r <= idx_r + 2'd1;
      end
      S_DONE: begin
        if (done_load) begin
          out_fault_r <= fault_r;
          if (fault_r != FLT_NONE) begin
            out_rdata_r <= '0;
            out_pa_r    <= '0;
          end else begin
            out_rdata_r <= wr_op_r ? '0 : rdata_merged;
            out_pa_r    <= pa_r[0];
          end
        end
      end
      default: ;
    endcase
  end

  a_acc_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken while an access is in flight");

  a_write_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_we != 4'b0000) |-> (fault_r == FLT_NONE) && $onehot(bank_we))
    else $error("memory written on a faulted access");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r != FLT_NONE) |-> (out_rdata_r == '0) && (out_pa_r == '0))
    else $error("faulted result carries data");

  a_capture_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cap_vld_r |-> $past(state_r == S_DATA) && !wr_op_r)
    else $error("read capture without a data read");

endmodule

// ===== tb/sv/paged_memory_access_unit_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_memory_access_unit_top_test
// Sets up page directories and tables through physical writes, then runs
// directed and random physical and virtual accesses under several register
// settings. The expected result of each access comes from a byte-level
// memory image and its own page walk, and is checked in order against every
// result word. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module paged_memory_access_unit_top_test;
  import pmau_pkg::*;

  localparam int unsigned MEM_BYTES    = MEM_BYTES_DEF;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 40;

  localparam logic [FUNC_W-1:0] PHYS_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] PHYS_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] VIRT_READ  = 2'd2;
  localparam logic [FUNC_W-1:0] VIRT_WRITE = 2'd3;

  localparam logic [FRAME_W-1:0] DIR_A     = 20'd1;
  localparam logic [FRAME_W-1:0] DIR_B     = 20'd2;
  localparam logic [FRAME_W-1:0] TAB_A     = 20'd3;
  localparam logic [FRAME_W-1:0] TAB_B     = 20'd4;
  localparam logic [FRAME_W-1:0] FRAME_TOP = 20'hfffff;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  access_len;
    logic [DATA_W-1:0] write_data;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] phys_address;
    fault_t            fault;
  } result_t;

  class access_scoreboard;
    logic [7:0]         mem_bytes [MEM_BYTES];
    bit                 written [MEM_BYTES];
    bit                 paging_on;
    logic [FRAME_W-1:0] dir_frame;
    bit                 unwritten_hit;
    result_t            expected_q [$];
    int unsigned        errors;

    function bit fits(logic [ADDR_W-1:0] a, int unsigned n);
      return (64'(a) + 64'(n)) <= 64'(MEM_BYTES);
    endfunction

    function fault_t fetch_entry(logic [ADDR_W-1:0] a, output logic [31:0] v);
      v = '0;
      if (!fits(a, 4)) return FLT_RANGE;
      for (int i = 0; i < 4; i++) begin
        if (!written[a + i]) unwritten_hit = 1'b1;
        v[8*i +: 8] = mem_bytes[a + i];
      end
      return FLT_NONE;
    endfunction

    function fault_t translate(logic [ADDR_W-1:0] va, output logic [ADDR_W-1:0] pa);
      logic [31:0] pde;
      logic [31:0] pte;
      fault_t      f;
      pa = va;
      if (!paging_on) return FLT_NONE;
      f = fetch_entry({dir_frame, va[ADDR_W-1:DIR_LSB], 2'b00}, pde);
      if (f != FLT_NONE) return f;
      if (!pde[ENTRY_PRESENT_BIT]) return FLT_DIR;
      f = fetch_entry({pde[31:PAGE_LSB], va[DIR_LSB-1:TAB_LSB], 2'b00}, pte);
      if (f != FLT_NONE) return f;
      if (!pte[ENTRY_PRESENT_BIT]) return FLT_TAB;
      pa = {pte[31:PAGE_LSB], va[PAGE_LSB-1:0]};
      return FLT_NONE;
    endfunction

    // commit=0 only works out whether the access would touch unwritten bytes
    function result_t apply(access_t acc, bit commit);
      logic [ADDR_W-1:0] pa [4];
      logic [ADDR_W-1:0] last;
      int unsigned       len;
      bit                wr_op;
      bit                is_virt;
      fault_t            f;
      result_t           r;
      unwritten_hit = 1'b0;
      f = FLT_NONE;
      len = (acc.access_len == 0) ? 1 : ((acc.access_len > 4) ? 4 : acc.access_len);
      wr_op = acc.func[FUNC_WRITE_BIT];
      is_virt = acc.func[FUNC_VIRT_BIT];
      last = acc.address + (len - 1);
      if (!is_virt) begin
        for (int i = 0; i < len; i++) pa[i] = acc.address + i;
      end else if (((last ^ acc.address) >> PAGE_LSB) != '0) begin
        for (int i = 0; i < len && f == FLT_NONE; i++) f = translate(acc.address + i, pa[i]);
      end else begin
        f = translate(acc.address, pa[0]);
        for (int i = 1; i < len; i++) pa[i] = pa[0] + i;
      end
      for (int i = 0; i < len && f == FLT_NONE; i++) begin
        if (!fits(pa[i], 1)) f = FLT_RANGE;
      end
      r.read_data = '0;
      r.phys_address = '0;
      r.fault = f;
      if (f != FLT_NONE) return r;
      for (int i = 0; i < len; i++) begin
        if (wr_op) begin
          if (commit) begin
            mem_bytes[pa[i]] = acc.write_data[8*i +: 8];
            written[pa[i]] = 1'b1;
          end
        end else begin
          if (!written[pa[i]]) unwritten_hit = 1'b1;
          r.read_data[8*i +: 8] = mem_bytes[pa[i]];
        end
      end
      r.phys_address = pa[0];
      return r;
    endfunction

    function bit is_safe(access_t acc);
      result_t r;
      r = apply(acc, 1'b0);
      return !unwritten_hit;
    endfunction

    function void note_access(access_t acc);
      expected_q.push_back(apply(acc, 1'b1));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_PAGING_EN: paging_on = data[0];
        CFG_DIR_FRAME: dir_frame = data[FRAME_W-1:0];
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [DATA_W-1:0] rd, logic [ADDR_W-1:0] pa, logic [FAULT_W-1:0] flt);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing pending", pa, '0);
        return;
      end
      want = expected_q.pop_front();
      if (flt !== want.fault) report_mismatch("fault", 32'(flt), 32'(want.fault));
      if (pa !== want.phys_address) report_mismatch("phys_address", pa, want.phys_address);
      if (rd !== want.read_data) report_mismatch("read_data", rd, want.read_data);
    endtask
  endclass

  logic clk;
  logic rst_n;

  pmau_in_if  in_ch ();
  pmau_out_if out_ch ();
  pmau_cfg_if cfg_ch ();

  paged_memory_access_unit_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  access_scoreboard sb = new;
  bit               in_steady;
  bit               out_steady;
  logic [1:0]       pace_phase = '0;
  int unsigned      quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.read_data, out_ch.phys_address, out_ch.fault);
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("paged_memory_access_unit_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic send_word(access_t a);
    int unsigned gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= a.func;
    in_ch.address    <= a.address;
    in_ch.access_len <= a.access_len;
    in_ch.write_data <= a.write_data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_access(a);
  endtask

  // drop anything that would read memory never written
  task automatic issue_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr,
                              logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
    access_t a;
    a = '{func: f, address: addr, access_len: len, write_data: data};
    if (sb.is_safe(a)) send_word(a);
  endtask

  task automatic put_entry(logic [FRAME_W-1:0] base, logic [9:0] idx, logic [31:0] value);
    issue_access(PHYS_WRITE, {base, idx, 2'b00}, 3'd4, value);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_index();
    case ($urandom_range(0, 7))
      0: return 10'h000;
      1: return 10'h001;
      2: return 10'h002;
      3: return 10'h003;
      4: return 10'h155;
      5: return 10'h200;
      6: return 10'h3ff;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic access_t random_access();
    access_t            a;
    logic [FRAME_W-1:0] frame;
    logic [11:0]        offset;
    int unsigned        sel;
    a.write_data = $urandom;
    a.access_len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
    offset = $urandom_range(0, 1) ? 12'hffc + 12'($urandom_range(0, 3)) : 12'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      a.func = $urandom_range(0, 1) ? VIRT_WRITE : VIRT_READ;
      a.address = {pick_index(), pick_index(), offset};
    end else if (sel < 80) begin
      a.func = $urandom_range(0, 1) ? PHYS_WRITE : PHYS_READ;
      frame = ($urandom_range(0, 3) == 0) ? '0 : 20'($urandom_range(5, 14));
      a.address = {frame, offset};
    end else if (sel < 90) begin
      a.func = PHYS_WRITE;
      a.access_len = 3'd4;
      if ($urandom_range(0, 4) == 0) begin
        frame = (sb.dir_frame < 16) ? sb.dir_frame : DIR_A;
        a.write_data[31:PAGE_LSB] = $urandom_range(0, 1) ? TAB_A : TAB_B;
      end else begin
        frame = $urandom_range(0, 1) ? TAB_A : TAB_B;
        a.write_data[31:PAGE_LSB] = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                                : 20'($urandom_range(5, 14));
      end
      a.write_data[ENTRY_PRESENT_BIT] = ($urandom_range(0, 3) != 0);
      a.address = {frame, pick_index(), 2'b00};
    end else begin
      a.func = 2'($urandom);
      a.access_len = 3'($urandom_range(0, 7));
      a.address = $urandom_range(0, 1) ? $urandom : 32'(MEM_BYTES - 8 + $urandom_range(0, 7));
    end
    return a;
  endfunction

  task automatic run_random(int unsigned count);
    access_t a;
    bit      sent;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        pace_phase++;
        in_steady = pace_phase[0];
        out_steady = pace_phase[1];
      end
      sent = 1'b0;
      for (int t = 0; t < 20 && !sent; t++) begin
        a = random_access();
        if (!sb.is_safe(a)) a.func[FUNC_WRITE_BIT] = 1'b1;
        if (sb.is_safe(a)) begin
          send_word(a);
          sent = 1'b1;
        end
      end
      if (!sent) begin
        a.func = PHYS_WRITE;
        a.address = 32'($urandom_range(0, 4091));
        send_word(a);
      end
    end
    in_steady = 1'b0;
    out_steady = 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= '0;
    in_ch.address    <= '0;
    in_ch.access_len <= '0;
    in_ch.write_data <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_PAGING_EN, 32'd0);
    write_reg(CFG_DIR_FRAME, 32'(DIR_A));

    // page tables: present, absent and out-of-range entries in both levels
    put_entry(DIR_A, 10'h000, {TAB_A, 12'h001});
    put_entry(DIR_A, 10'h3ff, {TAB_B, 12'h001});
    put_entry(DIR_A, 10'h001, 32'habcde000);
    put_entry(DIR_A, 10'h200, 32'h12345001);
    put_entry(DIR_B, 10'h000, {TAB_B, 12'hffd});
    put_entry(DIR_B, 10'h3ff, {TAB_A, 12'h001});
    put_entry(DIR_B, 10'h155, 32'h00000000);
    put_entry(TAB_A, 10'h000, 32'h00005007);
    put_entry(TAB_A, 10'h001, 32'h00006001);
    put_entry(TAB_A, 10'h002, 32'h00007000);
    put_entry(TAB_A, 10'h003, 32'hfffff001);
    put_entry(TAB_B, 10'h3ff, 32'h00008001);
    put_entry(TAB_B, 10'h000, 32'h00009001);

    // untranslated: memory top, length clamp, range faults, virtual as physical
    issue_access(PHYS_WRITE, 32'h0000fffc, 3'd4, 32'hdeadbeef);
    issue_access(PHYS_READ,  32'h0000fffc, 3'd4, 32'h0);
    issue_access(VIRT_READ,  32'h0000ffff, 3'd0, 32'hffffffff);
    issue_access(PHYS_READ,  32'h0000ffff, 3'd2, 32'h0);
    issue_access(PHYS_WRITE, 32'hffffffff, 3'd7, 32'h5a5aa5a5);
    issue_access(VIRT_WRITE, 32'h00005000, 3'd4, 32'h01234567);
    drain();

    write_reg(CFG_PAGING_EN, 32'd1);

    // translated: one page, page split, wrap, each fault and fault order
    issue_access(VIRT_READ,  32'h00000000, 3'd4, 32'h0);
    issue_access(VIRT_WRITE, 32'h00000ffe, 3'd4, 32'h89abcdef);
    issue_access(VIRT_READ,  32'h00000ffe, 3'd4, 32'h0);
    issue_access(VIRT_WRITE, 32'hfffffffe, 3'd4, 32'hc3d2e1f0);
    issue_access(VIRT_READ,  32'hfffffffe, 3'd5, 32'h0);
    issue_access(VIRT_READ,  32'h00400000, 3'd1, 32'h0);
    issue_access(VIRT_WRITE, 32'h00002000, 3'd2, 32'h11111111);
    issue_access(VIRT_WRITE, 32'h80000000, 3'd4, 32'h22222222);
    issue_access(VIRT_WRITE, 32'h00003000, 3'd2, 32'h33333333);
    issue_access(VIRT_WRITE, 32'h00001ffe, 3'd4, 32'h44444444);
    issue_access(PHYS_READ,  32'h00005000, 3'd3, 32'h0);
    issue_access(VIRT_READ,  32'hffffffff, 3'd1, 32'h0);
    drain();

    run_random(140);
    drain();
    write_reg(CFG_DIR_FRAME, 32'(DIR_B));
    run_random(90);
    drain();
    write_reg(CFG_DIR_FRAME, 32'(FRAME_TOP));
    run_random(30);
    drain();
    write_reg(CFG_PAGING_EN, 32'd0);
    write_reg(CFG_DIR_FRAME, 32'd0);
    run_random(60);
    drain();
    write_reg(CFG_PAGING_EN, 32'd1);
    run_random(60);
    drain();

    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("paged_memory_access_unit_top_test: PASS");
    end else begin
      $display("paged_memory_access_unit_top_test: FAIL");
    end
    $finish;
  end

endmodule
